### hdl/sto_pkg.sv
package sto_pkg;

   typedef struct packed {
      logic [31:0] deadline;
      logic [7:0]  handler;
      logic [15:0] context_id;
   } entry_type;

   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_CANCEL = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic [2:0] STATUS_ADDED      = 3'd0;
   localparam logic [2:0] STATUS_SUPERSEDED = 3'd1;
   localparam logic [2:0] STATUS_CANCELLED  = 3'd2;
   localparam logic [2:0] STATUS_NOT_FOUND  = 3'd3;
   localparam logic [2:0] STATUS_FULL       = 3'd4;
   localparam logic [2:0] STATUS_EXPIRED    = 3'd5;
   localparam logic [2:0] STATUS_NONE       = 3'd6;

   localparam int MAX_POP = 16;

endpackage

### hdl/sorted_timeout_queue.sv
// Sorted timeout queue. Timeouts keyed by handler and context are kept in one
// dual-port RAM in ascending deadline order; equal deadlines keep insertion
// order. One transaction is handled at a time. An add or cancel reads the
// queued entries once (one per cycle) and then shifts the entries between the
// old and new slot (all behind it, for a new entry or a cancel) by one slot,
// one per cycle; the next request can be taken in the cycle after its result
// is registered. A tick reads up to sixteen entries from the head to find the
// run of expired ones, returns each expired entry by reading it and then
// registering it once the result register is free, and then moves the
// remaining entries to the front at one per cycle. The single read and single
// write port of the RAM set these rates. A new request is taken while the last
// result still waits in the output register. The RAM needs no clearing pass.
module sorted_timeout_queue import sto_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,  // handler_id, context_id, deadline, now
   input  logic [1:0]  req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_handler, out_context
   output logic [2:0]  rsp_tuser,  // status
   output logic        rsp_tlast
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int PopLimit = (QUEUE_DEPTH < MAX_POP) ? QUEUE_DEPTH : MAX_POP;
   localparam logic [CW-1:0] POP_LIMIT = CW'(PopLimit);
   localparam logic [CW-1:0] DEPTH_FULL = CW'(QUEUE_DEPTH);
   localparam logic [CW-1:0] ONE = CW'(1);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SCAN      = 4'd1;
   localparam logic [3:0] S_DECIDE    = 4'd2;
   localparam logic [3:0] S_MOVE      = 4'd3;
   localparam logic [3:0] S_WRITE     = 4'd4;
   localparam logic [3:0] S_EMIT_RD   = 4'd5;
   localparam logic [3:0] S_EMIT_WAIT = 4'd6;
   localparam logic [3:0] S_RESP      = 4'd7;

   logic [3:0]    state_ff, state_in;
   logic [3:0]    next_ff, next_in;
   logic [1:0]    kind_ff, kind_in;
   logic [7:0]    handler_ff, handler_in;
   logic [15:0]   context_ff, context_in;
   logic [31:0]   time_ff, time_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] walk_cur_ff, walk_cur_in;
   logic [AW-1:0] walk_end_ff, walk_end_in;
   logic          walk_desc_ff, walk_desc_in;
   logic          walk_done_ff, walk_done_in;
   logic          rv_ff, rv_in;
   logic [AW-1:0] ridx_ff, ridx_in;
   logic [CW-1:0] dist_ff, dist_in;
   logic          found_ff, found_in;
   logic [CW-1:0] kpos_ff, kpos_in;
   logic [CW-1:0] le_ff, le_in;
   logic          run_ff, run_in;
   logic [CW-1:0] pop_ff, pop_in;
   logic [CW-1:0] emit_ff, emit_in;
   logic [CW-1:0] ins_ff, ins_in;
   logic [2:0]    status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [7:0]    rsp_handler_ff, rsp_handler_in;
   logic [15:0]   rsp_context_ff, rsp_context_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;

   logic          out_free;
   logic          key_match;
   logic          expired;
   logic [CW-1:0] scan_limit;
   logic [CW-1:0] ridx_ext;

   sto_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign key_match = (rd_data.handler == handler_ff) && (rd_data.context_id == context_ff);
   assign expired   = rd_data.deadline <= time_ff;
   assign ridx_ext  = CW'(ridx_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_context_ff, rsp_handler_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      if (req_tuser == REQ_TICK) begin
         scan_limit = (count_ff < POP_LIMIT) ? count_ff : POP_LIMIT;
      end else begin
         scan_limit = count_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      next_in        = next_ff;
      kind_in        = kind_ff;
      handler_in     = handler_ff;
      context_in     = context_ff;
      time_in        = time_ff;
      count_in       = count_ff;
      walk_cur_in    = walk_cur_ff;
      walk_end_in    = walk_end_ff;
      walk_desc_in   = walk_desc_ff;
      walk_done_in   = walk_done_ff;
      rv_in          = 1'b0;
      ridx_in        = walk_cur_ff;
      dist_in        = dist_ff;
      found_in       = found_ff;
      kpos_in        = kpos_ff;
      le_in          = le_ff;
      run_in         = run_ff;
      pop_in         = pop_ff;
      emit_in        = emit_ff;
      ins_in         = ins_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_handler_in = rsp_handler_ff;
      rsp_context_in = rsp_context_ff;
      rsp_last_in    = rsp_last_ff;
      rd_en          = 1'b0;
      rd_addr        = walk_cur_ff;
      wr_en          = 1'b0;
      wr_addr        = ridx_ff;
      wr_data        = rd_data;

      if ((state_ff inside {S_SCAN, S_MOVE}) && !walk_done_ff) begin
         rd_en = 1'b1;
         rv_in = 1'b1;
         if (walk_cur_ff == walk_end_ff) begin
            walk_done_in = 1'b1;
         end else if (walk_desc_ff) begin
            walk_cur_in = walk_cur_ff - AW'(1);
         end else begin
            walk_cur_in = walk_cur_ff + AW'(1);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in    = req_tuser;
               handler_in = req_tdata[7:0];
               context_in = req_tdata[23:8];
               time_in    = (req_tuser == REQ_TICK) ? req_tdata[87:56] : req_tdata[55:24];
               found_in   = 1'b0;
               le_in      = '0;
               pop_in     = '0;
               run_in     = 1'b1;
               if (req_tuser inside {REQ_ADD, REQ_CANCEL, REQ_TICK}) begin
                  if (count_ff == '0) begin
                     state_in = S_DECIDE;
                  end else begin
                     walk_cur_in  = '0;
                     walk_end_in  = AW'(scan_limit - ONE);
                     walk_desc_in = 1'b0;
                     walk_done_in = 1'b0;
                     state_in     = S_SCAN;
                  end
               end else begin
                  status_in = STATUS_NOT_FOUND;
                  state_in  = S_RESP;
               end
            end
         end

         S_SCAN: begin
            if (rv_ff) begin
               if (kind_ff == REQ_TICK) begin
                  if (run_ff && expired) begin
                     pop_in = pop_ff + ONE;
                  end else begin
                     run_in = 1'b0;
                  end
               end else begin
                  if (key_match) begin
                     found_in = 1'b1;
                     kpos_in  = ridx_ext;
                  end else if (expired) begin
                     le_in = le_ff + ONE;
                  end
               end
            end
            if (walk_done_ff && !rv_ff) begin
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            walk_done_in = 1'b0;
            dist_in      = ONE;
            case (kind_ff)
               REQ_ADD: begin
                  ins_in  = le_ff;
                  next_in = S_WRITE;
                  if (found_ff) begin
                     status_in = STATUS_SUPERSEDED;
                     if (le_ff > kpos_ff) begin
                        walk_cur_in  = AW'(kpos_ff + ONE);
                        walk_end_in  = AW'(le_ff);
                        walk_desc_in = 1'b0;
                        state_in     = S_MOVE;
                     end else if (le_ff < kpos_ff) begin
                        walk_cur_in  = AW'(kpos_ff - ONE);
                        walk_end_in  = AW'(le_ff);
                        walk_desc_in = 1'b1;
                        state_in     = S_MOVE;
                     end else begin
                        state_in = S_WRITE;
                     end
                  end else if (count_ff == DEPTH_FULL) begin
                     status_in = STATUS_FULL;
                     state_in  = S_RESP;
                  end else begin
                     status_in = STATUS_ADDED;
                     count_in  = count_ff + ONE;
                     if (le_ff < count_ff) begin
                        walk_cur_in  = AW'(count_ff - ONE);
                        walk_end_in  = AW'(le_ff);
                        walk_desc_in = 1'b1;
                        state_in     = S_MOVE;
                     end else begin
                        state_in = S_WRITE;
                     end
                  end
               end
               REQ_CANCEL: begin
                  next_in = S_RESP;
                  if (found_ff) begin
                     status_in = STATUS_CANCELLED;
                     count_in  = count_ff - ONE;
                     if ((kpos_ff + ONE) < count_ff) begin
                        walk_cur_in  = AW'(kpos_ff + ONE);
                        walk_end_in  = AW'(count_ff - ONE);
                        walk_desc_in = 1'b0;
                        state_in     = S_MOVE;
                     end else begin
                        state_in = S_RESP;
                     end
                  end else begin
                     status_in = STATUS_NOT_FOUND;
                     state_in  = S_RESP;
                  end
               end
               default: begin
                  if (pop_ff == '0) begin
                     status_in = STATUS_NONE;
                     state_in  = S_RESP;
                  end else begin
                     emit_in  = '0;
                     state_in = S_EMIT_RD;
                  end
               end
            endcase
         end

         S_MOVE: begin
            if (rv_ff) begin
               wr_en = 1'b1;
               if (walk_desc_ff) begin
                  wr_addr = AW'(ridx_ext + ONE);
               end else begin
                  wr_addr = AW'(ridx_ext - dist_ff);
               end
            end
            if (walk_done_ff && !rv_ff) begin
               state_in = next_ff;
            end
         end

         S_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = AW'(ins_ff);
            wr_data = '{deadline: time_ff, handler: handler_ff, context_id: context_ff};
            state_in = S_RESP;
         end

         S_EMIT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(emit_ff);
            state_in = S_EMIT_WAIT;
         end

         S_EMIT_WAIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STATUS_EXPIRED;
               rsp_handler_in = rd_data.handler;
               rsp_context_in = rd_data.context_id;
               rsp_last_in    = (emit_ff == pop_ff - ONE);
               if (emit_ff == pop_ff - ONE) begin
                  count_in = count_ff - pop_ff;
                  if (pop_ff < count_ff) begin
                     walk_cur_in  = AW'(pop_ff);
                     walk_end_in  = AW'(count_ff - ONE);
                     walk_desc_in = 1'b0;
                     walk_done_in = 1'b0;
                     dist_in      = pop_ff;
                     next_in      = S_IDLE;
                     state_in     = S_MOVE;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  emit_in  = emit_ff + ONE;
                  state_in = S_EMIT_RD;
               end
            end
         end

         S_RESP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_handler_in = '0;
               rsp_context_in = '0;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rv_ff        <= 1'b0;
         walk_done_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rv_ff        <= rv_in;
         walk_done_ff <= walk_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      next_ff        <= next_in;
      kind_ff        <= kind_in;
      handler_ff     <= handler_in;
      context_ff     <= context_in;
      time_ff        <= time_in;
      walk_cur_ff    <= walk_cur_in;
      walk_end_ff    <= walk_end_in;
      walk_desc_ff   <= walk_desc_in;
      ridx_ff        <= ridx_in;
      dist_ff        <= dist_in;
      found_ff       <= found_in;
      kpos_ff        <= kpos_in;
      le_ff          <= le_in;
      run_ff         <= run_in;
      pop_ff         <= pop_in;
      emit_ff        <= emit_in;
      ins_ff         <= ins_in;
      status_ff      <= status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_handler_ff <= rsp_handler_in;
      rsp_context_ff <= rsp_context_in;
      rsp_last_ff    <= rsp_last_in;
   end

endmodule

### hdl/sto_ram.sv
module sto_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### hdl/sto_checker.sv
module sto_checker import sto_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("Stalled result transaction changed.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Request taken while the previous one is still in work.");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_EXPIRED |-> rsp_tlast && rsp_tdata == '0)
      else $error("Single result without last mark or with payload.");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= STATUS_NONE)
      else $error("Result status out of range.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

endmodule

bind sorted_timeout_queue sto_checker u_sto_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
